[rtl/core/mctt_pkg.sv]
// ----------------------------------------------------------------------------
// mctt_pkg
// shared types and constants of the multi-channel timeout timer
// ----------------------------------------------------------------------------
package mctt_pkg;

    localparam int NUM_CHANNELS_DEF = 8;

    // word field widths
    localparam int MODE_W     = 2;
    localparam int CHAN_W     = 3;
    localparam int TICK_W     = 32;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 40;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK  = 2'd0,
        MODE_START = 2'd1,
        MODE_SCAN  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_FLUSH
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic tick_inc;
        logic start_wr;
        logic scan_begin;
        logic advance;
        logic flush;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic expire;
        logic can_advance;
        logic idx_last;
        logic out_free;
        logic pend_valid;
    } st_t;

endpackage

[rtl/core/mctt_ram.sv]
// ----------------------------------------------------------------------------
// mctt_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module mctt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/mctt_ctrl.sv]
// ----------------------------------------------------------------------------
// mctt_ctrl
// sequencer for tick, start and scan words
// ----------------------------------------------------------------------------
module mctt_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    input  mctt_pkg::mode_t mode,
    output logic            s_tready,
    input  mctt_pkg::st_t   st,
    output mctt_pkg::cmd_t  cmd
);

    import mctt_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    unique case (mode)
                        MODE_TICK:  cmd.tick_inc = 1'b1;
                        MODE_START: cmd.start_wr = 1'b1;
                        MODE_SCAN:
                        begin
                            cmd.scan_begin = 1'b1;
                            state_next     = ST_EVAL;
                        end
                        default: ;
                    endcase
                end
            end
            ST_EVAL:
            begin
                // hold an expiry while an older report waits for the output
                if (st.can_advance)
                begin
                    cmd.advance = 1'b1;
                    if (st.idx_last)
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (st.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

[rtl/core/mctt_dp.sv]
// ----------------------------------------------------------------------------
// mctt_dp
// tick counter, channel tables, expiry compare and output register
// ----------------------------------------------------------------------------
module mctt_dp #(
    parameter int NUM_CHANNELS = mctt_pkg::NUM_CHANNELS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [mctt_pkg::CHAN_W-1:0]   channel,
    input  logic [mctt_pkg::TICK_W-1:0]   period,
    input  logic                          repeat_req,
    input  mctt_pkg::cmd_t                cmd,
    output mctt_pkg::st_t                 st,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic                          fired,
    output logic [mctt_pkg::CHAN_W-1:0]   expired_channel,
    output logic [mctt_pkg::TICK_W-1:0]   tick_now,
    output logic                          last
);

    import mctt_pkg::*;

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic [TICK_W-1:0]       tick_reg;
    logic [NUM_CHANNELS-1:0] en_reg;
    logic [NUM_CHANNELS-1:0] en_next;
    logic [NUM_CHANNELS-1:0] periodic_reg;
    logic [NUM_CHANNELS-1:0] periodic_next;
    logic [CH_W-1:0]         idx_reg;
    logic                    pend_valid_reg;
    logic [CH_W-1:0]         pend_ch_reg;
    logic                    out_valid_reg;
    logic                    fired_reg;
    logic [CHAN_W-1:0]       out_ch_reg;
    logic [TICK_W-1:0]       out_tick_reg;
    logic                    last_reg;

    logic [CH_W-1:0]   start_idx;
    logic              start_ok;
    logic              idx_last;
    logic              out_free;
    logic              expire;
    logic              commit;
    logic              push_pend;
    logic [TICK_W-1:0] ref_rd;
    logic [TICK_W-1:0] per_rd;
    logic [TICK_W-1:0] due;
    logic              ram_re;
    logic [CH_W-1:0]   ram_raddr;
    logic [CH_W-1:0]   ram_waddr;
    logic              ref_we;
    logic              per_we;

    assign start_idx = CH_W'(channel);
    assign start_ok  = cmd.start_wr && (32'(channel) < 32'(NUM_CHANNELS));
    assign idx_last  = (idx_reg == CH_W'(NUM_CHANNELS - 1));
    assign out_free  = !out_valid_reg || m_tready;

    // expiry: wrapped sum, unsigned compare
    assign due    = ref_rd + per_rd;
    assign expire = en_reg[idx_reg] && (tick_reg >= due);
    assign commit = cmd.advance && expire;
    assign push_pend = commit && pend_valid_reg;

    // read ahead: next channel is fetched as the current one advances
    assign ram_re    = cmd.scan_begin || (cmd.advance && !idx_last);
    assign ram_raddr = cmd.scan_begin ? '0 : idx_reg + 1'b1;
    assign ram_waddr = cmd.start_wr ? start_idx : idx_reg;
    assign per_we    = start_ok;
    assign ref_we    = start_ok || (commit && periodic_reg[idx_reg]);

    mctt_ram #(
        .WIDTH (TICK_W),
        .DEPTH (NUM_CHANNELS)
    ) u_ref_ram (
        .clk   (clk),
        .we    (ref_we),
        .waddr (ram_waddr),
        .wdata (tick_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ref_rd)
    );

    mctt_ram #(
        .WIDTH (TICK_W),
        .DEPTH (NUM_CHANNELS)
    ) u_per_ram (
        .clk   (clk),
        .we    (per_we),
        .waddr (ram_waddr),
        .wdata (period),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (per_rd)
    );

    always_comb
    begin
        en_next       = en_reg;
        periodic_next = periodic_reg;
        if (start_ok)
        begin
            en_next[start_idx]       = 1'b1;
            periodic_next[start_idx] = repeat_req;
        end
        if (commit && !periodic_reg[idx_reg])
        begin
            en_next[idx_reg] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg       <= '0;
            en_reg         <= '0;
            periodic_reg   <= '0;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            en_reg       <= en_next;
            periodic_reg <= periodic_next;
            if (cmd.tick_inc)
            begin
                tick_reg <= tick_reg + 1'b1;
            end
            if (cmd.scan_begin)
            begin
                idx_reg        <= '0;
                pend_valid_reg <= 1'b0;
            end
            else if (cmd.advance)
            begin
                idx_reg <= idx_reg + 1'b1;
                if (expire)
                begin
                    pend_valid_reg <= 1'b1;
                end
            end
            if (push_pend || cmd.flush)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            pend_ch_reg <= idx_reg;
        end
        if (push_pend)
        begin
            fired_reg    <= 1'b1;
            out_ch_reg   <= CHAN_W'(pend_ch_reg);
            out_tick_reg <= tick_reg;
            last_reg     <= 1'b0;
        end
        else if (cmd.flush)
        begin
            fired_reg    <= pend_valid_reg;
            out_ch_reg   <= pend_valid_reg ? CHAN_W'(pend_ch_reg) : '0;
            out_tick_reg <= tick_reg;
            last_reg     <= 1'b1;
        end
    end

    assign st.expire      = expire;
    assign st.can_advance = !(expire && pend_valid_reg && !out_free);
    assign st.idx_last    = idx_last;
    assign st.out_free    = out_free;
    assign st.pend_valid  = pend_valid_reg;

    assign m_tvalid        = out_valid_reg;
    assign fired           = fired_reg;
    assign expired_channel = out_ch_reg;
    assign tick_now        = out_tick_reg;
    assign last            = last_reg;

endmodule

[rtl/core/multi_channel_timeout_timer_core.sv]
// ----------------------------------------------------------------------------
// multi_channel_timeout_timer_core
// timer channel table with free-running tick counter and expiry scan
// ----------------------------------------------------------------------------
//
//  channel  | direction | tdata (lsb up)                      | tuser   | tlast
//  ---------+-----------+-------------------------------------+---------+------
//  s_*      | in        | channel[2:0] period[34:3] rpt[35]   | mode    | -
//  m_*      | out       | expired_channel[2:0] tick_now[34:3] | fired   | last
//
//  tick and start words are applied as they are accepted; the sequencer stays idle
//  a scan opens by fetching channel zero, then checks one channel a cycle when not held
//  through the registered read of the period and reference rams, and ends
//  by sending the final word
//  a full output register holds the scan on the next expired channel
//  asynchronous active-low reset clears the counter and all channel enables
//
// ----------------------------------------------------------------------------
module multi_channel_timeout_timer_core #(
    parameter int NUM_CHANNELS = mctt_pkg::NUM_CHANNELS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // input words
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [mctt_pkg::S_TDATA_W-1:0] s_tdata,  // channel, period, repeat_req, zero pad
    input  logic [mctt_pkg::MODE_W-1:0]    s_tuser,  // mode
    // result words
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [mctt_pkg::M_TDATA_W-1:0] m_tdata,  // expired_channel, tick_now, zero pad
    output logic [0:0]                     m_tuser,  // fired
    output logic                           m_tlast
);

    import mctt_pkg::*;

    cmd_t  cmd;
    st_t   st;
    mode_t mode;

    logic [CHAN_W-1:0] expired_channel;
    logic [TICK_W-1:0] tick_now;
    logic              fired;

    // unused code three falls through the decoder as a dropped word
    assign mode = mode_t'(s_tuser);

    mctt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .mode     (mode),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    mctt_dp #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .channel         (s_tdata[CHAN_W-1:0]),
        .period          (s_tdata[CHAN_W +: TICK_W]),
        .repeat_req      (s_tdata[CHAN_W + TICK_W]),
        .cmd             (cmd),
        .st              (st),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .fired           (fired),
        .expired_channel (expired_channel),
        .tick_now        (tick_now),
        .last            (m_tlast)
    );

    // pack result word, pad bits tied low
    assign m_tdata    = M_TDATA_W'({tick_now, expired_channel});
    assign m_tuser[0] = fired;

`ifndef NO_ASSERTIONS
    // a word reporting no expiry always closes its scan
    a_nofire_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tlast)
        else $error("non-firing result without last");

    // flushing a scan leaves a final word in the output register
    a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flush |=> m_tvalid && m_tlast)
        else $error("scan flush did not present a last word");

    // a second expiry pushes the held one out as a non-final report
    a_push_mid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.advance && st.expire && st.pend_valid |=> m_tvalid && m_tuser[0] && !m_tlast)
        else $error("held expiry not pushed as a mid-scan report");

    // no input word is taken while a scan is in progress
    a_scan_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_begin |=> !s_tready)
        else $error("input accepted during scan");
`endif

endmodule
